// ----- hdl/isl_pkg.sv -----
// Shared types and constants for the indexed min-heap seed list.
package isl_pkg;

  localparam logic CMD_UPDATE  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_LOWERED   = 3'd1;
  localparam logic [2:0] ST_IGNORED   = 3'd2;
  localparam logic [2:0] ST_EXTRACTED = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  localparam int unsigned ID_BITS  = 10;
  localparam int unsigned KEY_W    = 32;

  typedef struct packed {
    logic                cmd;
    logic [ID_BITS-1:0]  point_id;
    logic [KEY_W-1:0]    key;
  } isl_in_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [ID_BITS-1:0]  out_point;
    logic [KEY_W-1:0]    out_key;
    logic                out_infinite;
    logic [10:0]         entry_total;
  } isl_out_t;

  // Classified word handed from the front queue to the heap engine.
  typedef struct packed {
    logic                cmd;
    logic                in_range;
    logic [ID_BITS-1:0]  point_id;
    logic [KEY_W-1:0]    key;
  } isl_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_EX_TAKE,
    S_LOOK,
    S_LOW_CMP,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_FINAL,
    S_RESULT
  } isl_state_t;

endpackage

// ----- hdl/indexed_min_heap_seed_list.sv -----
// Top level of the indexed min-heap seed list with its output register.
//
//   channel  | ports                          | word
//   ---------+--------------------------------+------------------------------
//   input    | in_valid, in_stall, in_data    | cmd, point_id, key
//   result   | out_valid, out_stall, out_data | status, point, key, inf, total
//
// Each command walks the engine's states, from IDLE and DISPATCH straight to
// RESULT (extract on an empty heap) up to a full sift; every heap level of a
// sift costs a read state and a compare/move state on the heap memory's ports.
// The result then passes through the result register.
// After reset the position map is swept to "not seen", entry by entry;
// commands queue in the front (two words) but are not executed meanwhile.
// The input queue and the result register let each side stall on its own.
module indexed_min_heap_seed_list #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned KEY_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  isl_pkg::isl_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output isl_pkg::isl_out_t  out_data
);
  import isl_pkg::*;

  logic       q_valid, q_pop;
  isl_item_t  q_item;
  logic       res_valid, res_ready;
  isl_out_t   res;
  logic       out_valid_r;
  isl_out_t   out_data_r;

  // Classify and buffer incoming words.
  isl_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_item, .q_pop
  );

  // Run the heap operation for one word at a time.
  isl_engine #(.MAX_POINTS(MAX_POINTS), .KEY_BITS(KEY_BITS)) u_engine (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .res_valid, .res_ready, .res
  );

  // Hold the result until the sink takes it; reload as it drains.
  assign res_ready = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_data_r <= res;
  end

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.entry_total) <= 32'(MAX_POINTS))
    else $error("entry total above capacity");

  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |-> out_data.entry_total == '0)
    else $error("empty report with entries present");

  a_inf_extract: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_infinite |-> out_data.status == ST_EXTRACTED)
    else $error("infinite flag without extract");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("engine result dropped while output held");

endmodule

// ----- hdl/isl_front.sv -----
// Input side: classify incoming words and queue them for the heap engine.
module isl_front #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  isl_pkg::isl_in_t  in_data,
  output logic              q_valid,
  output isl_pkg::isl_item_t q_item,
  input  logic              q_pop
);
  import isl_pkg::*;

  isl_item_t  slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  isl_item_t  cls;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rp_r];

  always_comb begin
    cls.cmd      = in_data.cmd;
    cls.point_id = in_data.point_id;
    cls.key      = in_data.key;
    cls.in_range = (32'(in_data.point_id) < 32'(MAX_POINTS));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop && q_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop && q_valid);
    end
  end

endmodule

// ----- hdl/isl_engine.sv -----
// Heap engine: position map, heap storage and the sift sequencer.
module isl_engine #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned KEY_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  isl_pkg::isl_item_t  q_item,
  output logic                q_pop,
  output logic                res_valid,
  input  logic                res_ready,
  output isl_pkg::isl_out_t   res
);
  import isl_pkg::*;

  localparam int unsigned PW  = $clog2(MAX_POINTS);
  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned PCW = $clog2(MAX_POINTS + 2);
  localparam int unsigned XW  = PW + 2;
  localparam logic [PCW-1:0] POS_NOT_SEEN = PCW'(MAX_POINTS);
  localparam logic [PCW-1:0] POS_HANDLED  = PCW'(MAX_POINTS + 1);

  logic [PCW-1:0]      pos_mem [MAX_POINTS];
  logic [KEY_BITS-1:0] hk_mem  [MAX_POINTS];
  logic [PW-1:0]       hp_mem  [MAX_POINTS];

  isl_state_t          state_r, state_nxt;
  logic                cmd_r, cmd_nxt;
  logic                inr_r, inr_nxt;
  logic [PW-1:0]       id_r, id_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [PW-1:0]       hole_r, hole_nxt;
  logic [PW:0]         c_r, c_nxt;
  logic [KEY_BITS-1:0] mk_r, mk_nxt;
  logic [PW-1:0]       mp_r, mp_nxt;
  logic                moved_r, moved_nxt;
  logic [2:0]          status_r, status_nxt;
  logic [PW-1:0]       opoint_r, opoint_nxt;
  logic [KEY_BITS-1:0] okey_r, okey_nxt;
  logic [PW-1:0]       clr_r, clr_nxt;

  logic [PCW-1:0]      pos_rd_r;
  logic [KEY_BITS-1:0] rk0_r, rk1_r;
  logic [PW-1:0]       rp0_r, rp1_r;

  logic                pos_we;
  logic [PW-1:0]       pos_wa, pos_ra;
  logic [PCW-1:0]      pos_wd;
  logic                h_we;
  logic [PW-1:0]       h_wa, ra0, ra1;
  logic [KEY_BITS-1:0] h_wk;
  logic [PW-1:0]       h_wp;

  logic [PW-1:0]       parent;
  logic [PW:0]         child;
  logic                no_child, has_right, pick_right;
  logic [KEY_BITS-1:0] ch_key;
  logic [PW-1:0]       ch_pt, ch_idx;
  logic                up_less, dn_less, seen_not, pos_live, cnt_zero, cnt_one, cnt_full;

  assign parent     = (hole_r - PW'(1)) >> 1;
  assign child      = {hole_r, 1'b1};
  assign no_child   = XW'(child) >= XW'(count_r);
  assign has_right  = (XW'(c_r) + XW'(1)) < XW'(count_r);
  assign pick_right = has_right && (rk1_r < rk0_r);
  assign ch_key     = pick_right ? rk1_r : rk0_r;
  assign ch_pt      = pick_right ? rp1_r : rp0_r;
  assign ch_idx     = pick_right ? PW'(c_r + 1'b1) : PW'(c_r);
  assign up_less    = mk_r < rk0_r;
  assign dn_less    = ch_key < mk_r;
  assign seen_not   = (pos_rd_r == POS_NOT_SEEN);
  assign pos_live   = PCW'(pos_rd_r) < PCW'(count_r);
  assign cnt_zero   = (count_r == '0);
  assign cnt_one    = (count_r == CW'(1));
  assign cnt_full   = (32'(count_r) >= 32'(MAX_POINTS));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:    if (32'(clr_r) == 32'(MAX_POINTS - 1)) state_nxt = S_IDLE;
      S_IDLE:     if (q_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        if (cmd_r == CMD_EXTRACT) state_nxt = cnt_zero ? S_RESULT : S_EX_TAKE;
        else state_nxt = inr_r ? S_LOOK : S_RESULT;
      end
      S_EX_TAKE:  state_nxt = cnt_one ? S_RESULT : S_DN_RD;
      S_LOOK: begin
        if (seen_not) state_nxt = cnt_full ? S_RESULT : S_UP_RD;
        else if (pos_live) state_nxt = S_LOW_CMP;
        else state_nxt = S_RESULT;
      end
      S_LOW_CMP:  state_nxt = (rk0_r > key_r) ? S_UP_RD : S_RESULT;
      S_UP_RD: begin
        if (hole_r == '0) state_nxt = moved_r ? S_FINAL : S_DN_RD;
        else state_nxt = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (up_less) state_nxt = S_UP_RD;
        else state_nxt = moved_r ? S_FINAL : S_DN_RD;
      end
      S_DN_RD:    state_nxt = no_child ? S_FINAL : S_DN_CMP;
      S_DN_CMP:   state_nxt = dn_less ? S_DN_RD : S_FINAL;
      S_FINAL:    state_nxt = S_RESULT;
      S_RESULT:   if (res_ready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_nxt = cmd_r; inr_nxt = inr_r; id_nxt = id_r; key_nxt = key_r;
    count_nxt = count_r; hole_nxt = hole_r; c_nxt = c_r;
    mk_nxt = mk_r; mp_nxt = mp_r; moved_nxt = moved_r;
    status_nxt = status_r; opoint_nxt = opoint_r; okey_nxt = okey_r;
    clr_nxt = clr_r;
    q_pop = 1'b0; res_valid = 1'b0;
    pos_we = 1'b0; pos_wa = '0; pos_wd = '0; pos_ra = '0;
    h_we = 1'b0; h_wa = '0; h_wk = '0; h_wp = '0; ra0 = '0; ra1 = '0;
    case (state_r)
      S_CLEAR: begin
        pos_we = 1'b1; pos_wa = clr_r; pos_wd = POS_NOT_SEEN;
        clr_nxt = clr_r + PW'(1);
      end
      S_IDLE: begin
        q_pop   = q_valid;
        cmd_nxt = q_item.cmd;
        inr_nxt = q_item.in_range;
        id_nxt  = PW'(q_item.point_id);
        key_nxt = KEY_BITS'(q_item.key);
      end
      S_DISPATCH: begin
        status_nxt = ST_IGNORED; opoint_nxt = '0; okey_nxt = '0;
        if (cmd_r == CMD_EXTRACT) begin
          if (cnt_zero) status_nxt = ST_EMPTY;
          ra0 = '0; ra1 = PW'(count_r - CW'(1));
        end else begin
          pos_ra = id_r;
        end
      end
      S_EX_TAKE: begin
        status_nxt = ST_EXTRACTED; opoint_nxt = rp0_r; okey_nxt = rk0_r;
        pos_we = 1'b1; pos_wa = rp0_r; pos_wd = POS_HANDLED;
        count_nxt = count_r - CW'(1);
        mk_nxt = rk1_r; mp_nxt = rp1_r; hole_nxt = '0; moved_nxt = 1'b0;
      end
      S_LOOK: begin
        moved_nxt = 1'b0;
        if (seen_not) begin
          if (!cnt_full) begin
            mk_nxt = key_r; mp_nxt = id_r; hole_nxt = PW'(count_r);
            count_nxt = count_r + CW'(1); status_nxt = ST_INSERTED;
          end
        end else if (pos_live) begin
          hole_nxt = PW'(pos_rd_r); ra0 = PW'(pos_rd_r);
        end
      end
      S_LOW_CMP: begin
        if (rk0_r > key_r) begin
          mk_nxt = key_r; mp_nxt = rp0_r; status_nxt = ST_LOWERED;
        end
      end
      S_UP_RD: ra0 = parent;
      S_UP_CMP: begin
        if (up_less) begin
          h_we = 1'b1; h_wa = hole_r; h_wk = rk0_r; h_wp = rp0_r;
          pos_we = 1'b1; pos_wa = rp0_r; pos_wd = PCW'(hole_r);
          hole_nxt = parent; moved_nxt = 1'b1;
        end
      end
      S_DN_RD: begin
        c_nxt = child; ra0 = PW'(child); ra1 = PW'(child + 1'b1);
      end
      S_DN_CMP: begin
        if (dn_less) begin
          h_we = 1'b1; h_wa = hole_r; h_wk = ch_key; h_wp = ch_pt;
          pos_we = 1'b1; pos_wa = ch_pt; pos_wd = PCW'(hole_r);
          hole_nxt = ch_idx;
        end
      end
      S_FINAL: begin
        h_we = 1'b1; h_wa = hole_r; h_wk = mk_r; h_wp = mp_r;
        pos_we = 1'b1; pos_wa = mp_r; pos_wd = PCW'(hole_r);
      end
      S_RESULT: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    res.status       = status_r;
    res.out_point    = ID_BITS'(opoint_r);
    res.out_key      = KEY_W'(okey_r);
    res.out_infinite = (status_r == ST_EXTRACTED) && (okey_r == '1);
    res.entry_total  = 11'(count_r);
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_rd_r <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      hk_mem[h_wa] <= h_wk;
      hp_mem[h_wa] <= h_wp;
    end
    rk0_r <= hk_mem[ra0];
    rp0_r <= hp_mem[ra0];
    rk1_r <= hk_mem[ra1];
    rp1_r <= hp_mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      count_r <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; inr_r <= inr_nxt; id_r <= id_nxt; key_r <= key_nxt;
    hole_r <= hole_nxt; c_r <= c_nxt; mk_r <= mk_nxt; mp_r <= mp_nxt;
    moved_r <= moved_nxt; status_r <= status_nxt;
    opoint_r <= opoint_nxt; okey_r <= okey_nxt;
  end

endmodule
